[design/lcdws_pkg.sv]
// ----------------------------------------------------------------------------
// lcdws_pkg
// Shared types and constants for the character LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdws_pkg;

    localparam int WAIT_W = 13;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;

    // Input function codes
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_PUSH  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_e_t;

    // Queue entry kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_DELAY       = 3'd0,
        KIND_INIT30_SLOW = 3'd1,
        KIND_INIT30      = 3'd2,
        KIND_INIT20      = 3'd3,
        KIND_COMMAND     = 3'd4,
        KIND_DATA        = 3'd5
    } entry_kind_e_t;

    // Result kinds
    typedef enum logic [1:0] {
        RK_ACCEPT  = 2'd0,
        RK_FULL    = 2'd1,
        RK_STROBE  = 2'd2,
        RK_CLEARED = 2'd3
    } result_kind_e_t;

    // Base execution times in microseconds; the wait is d + d/8 + 1
    localparam int D_DELAY     = 4000;
    localparam int D_INIT_SLOW = 4100;
    localparam int D_INIT      = 100;
    localparam int D_DATA      = 41;
    localparam int D_CMD       = 37;
    localparam int D_CMD_HOME  = 1520;
    localparam int D_NONE      = 0;

    localparam logic [WAIT_W-1:0] WAIT_DELAY     = WAIT_W'(D_DELAY + D_DELAY / 8 + 1);
    localparam logic [WAIT_W-1:0] WAIT_INIT_SLOW =
        WAIT_W'(D_INIT_SLOW + D_INIT_SLOW / 8 + 1);
    localparam logic [WAIT_W-1:0] WAIT_INIT      = WAIT_W'(D_INIT + D_INIT / 8 + 1);
    localparam logic [WAIT_W-1:0] WAIT_DATA      = WAIT_W'(D_DATA + D_DATA / 8 + 1);
    localparam logic [WAIT_W-1:0] WAIT_CMD       = WAIT_W'(D_CMD + D_CMD / 8 + 1);
    localparam logic [WAIT_W-1:0] WAIT_CMD_HOME  =
        WAIT_W'(D_CMD_HOME + D_CMD_HOME / 8 + 1);
    localparam logic [WAIT_W-1:0] WAIT_NONE      = WAIT_W'(D_NONE + D_NONE / 8 + 1);

    // Upper-nibble patterns of the init entries
    localparam logic [3:0] NIBBLE_INIT30 = 4'h3;
    localparam logic [3:0] NIBBLE_INIT20 = 4'h2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } queue_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        result_kind_e_t    kind;
        logic              reg_select;
        logic [BYTE_W-1:0] bus_value;
        logic              last;
        logic [WAIT_W-1:0] wait_us;
    } result_t;

    typedef struct packed {
        logic    en0;
        logic    en1;
        result_t res0;
        result_t res1;
    } result_wr_t;

endpackage

[design/char_lcd_write_sequencer.sv]
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer
// Queued write sequencer for a character LCD: entry queue, wait timer and
// enable-strobe generation in 8-bit or 4-bit bus mode.
// ----------------------------------------------------------------------------
// Path: an input word is taken into the input register; its result words are
// written into the result buffer from there and are then valid on the master side.
// Throughput: one input word per cycle while the four-word result buffer holds
// at most two words, as an input word can cause up to two (the two strobes of a
// 4-bit mode byte); master-side stalls and back-to-back strobes can fill it.
// Reset: queue pointers, wait timer, bus levels and bus mode clear at once;
// the queue storage is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer
    import lcdws_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Bus mode register
    input  logic        cfg_we,
    input  logic        cfg_wdata,      // four_bit_mode

    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] entry_byte
    input  logic [4:0]  s_tuser,        // [1:0] func, [4:2] entry_kind

    // Result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,        // [0] reg_select, [8:1] bus_value,
                                        // [21:9] wait_us, [23:22] zero
    output logic [1:0]  m_tuser,        // [1:0] result_kind
    output logic        m_tlast         // last
);

    // ------------------------------------------------------------------
    // Input register: holds one word until the result buffer has room for
    // the up to two words it can cause.
    // ------------------------------------------------------------------
    logic              in_valid_reg;
    func_e_t           in_func_reg;
    logic [KIND_W-1:0] in_kind_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    logic              mode_reg;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [BYTE_W-1:0] bus_reg, bus_next;

    queue_ctrl_t       q_ctrl;
    queue_status_t     q_status;
    entry_t            q_push_entry;
    entry_t            q_head;

    result_wr_t        res_wr;
    result_t           out_result;
    logic              room2;
    logic              fire;

    logic              strobe_rs;
    logic [WAIT_W-1:0] strobe_wait;
    logic [3:0]        init_nibble;

    assign fire     = in_valid_reg && room2;
    assign s_tready = !in_valid_reg || room2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_func_reg <= func_e_t'(s_tuser[1:0]);
            in_kind_reg <= s_tuser[4:2];
            in_byte_reg <= s_tdata;
        end
    end

    // Bus mode: the user must write it only while the block is idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Entry queue
    // ------------------------------------------------------------------
    assign q_push_entry.kind = in_kind_reg;
    assign q_push_entry.data = in_byte_reg;

    lcdws_entry_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (q_ctrl),
        .push_entry (q_push_entry),
        .status     (q_status),
        .head_entry (q_head)
    );

    // ------------------------------------------------------------------
    // Wait time and register select of a command or data entry.
    // Clear-display and return-home commands (only bits 1..0 set) run long.
    // ------------------------------------------------------------------
    always_comb
    begin
        strobe_rs = (q_head.kind == KIND_DATA);
        if (strobe_rs)
        begin
            strobe_wait = WAIT_DATA;
        end
        else if (q_head.data[7:2] != '0)
        begin
            strobe_wait = WAIT_CMD;
        end
        else if (q_head.data[1:0] != '0)
        begin
            strobe_wait = WAIT_CMD_HOME;
        end
        else
        begin
            strobe_wait = WAIT_CMD;
        end
        init_nibble = (q_head.kind == KIND_INIT20) ? NIBBLE_INIT20 : NIBBLE_INIT30;
    end

    // ------------------------------------------------------------------
    // Sequencing: decode the held word against the timer and queue head,
    // update state and emit result words.
    // ------------------------------------------------------------------
    always_comb
    begin
        q_ctrl    = '0;
        wait_next = wait_reg;
        bus_next  = bus_reg;
        res_wr    = '0;
        res_wr.res0.kind = RK_ACCEPT;
        res_wr.res1.kind = RK_STROBE;
        if (fire)
        begin
            unique case (in_func_reg)
                FUNC_PUSH:
                begin
                    res_wr.en0       = 1'b1;
                    res_wr.res0.last = 1'b1;
                    if (q_status.full)
                    begin
                        res_wr.res0.kind = RK_FULL;
                    end
                    else
                    begin
                        q_ctrl.push      = 1'b1;
                        res_wr.res0.kind = RK_ACCEPT;
                    end
                end
                FUNC_CLEAR:
                begin
                    q_ctrl.clear     = 1'b1;
                    wait_next        = '0;
                    res_wr.en0       = 1'b1;
                    res_wr.res0.kind = RK_CLEARED;
                    res_wr.res0.last = 1'b1;
                end
                FUNC_TICK:
                begin
                    if (wait_reg != '0)
                    begin
                        // count the pending wait down
                        wait_next = wait_reg - 1'b1;
                    end
                    else if (!q_status.empty)
                    begin
                        q_ctrl.pop = 1'b1;
                        unique case (q_head.kind) inside
                            KIND_DELAY:
                            begin
                                wait_next = WAIT_DELAY;
                            end
                            KIND_INIT30_SLOW, KIND_INIT30, KIND_INIT20:
                            begin
                                // drive lines 7..4 only, keep 3..0
                                bus_next  = {init_nibble, bus_reg[3:0]};
                                wait_next = (q_head.kind == KIND_INIT30_SLOW)
                                            ? WAIT_INIT_SLOW : WAIT_INIT;
                                res_wr.en0             = 1'b1;
                                res_wr.res0.kind       = RK_STROBE;
                                res_wr.res0.bus_value  = bus_next;
                                res_wr.res0.last       = 1'b1;
                                res_wr.res0.wait_us    = wait_next;
                            end
                            KIND_COMMAND, KIND_DATA:
                            begin
                                wait_next              = strobe_wait;
                                res_wr.en0             = 1'b1;
                                res_wr.res0.kind       = RK_STROBE;
                                res_wr.res0.reg_select = strobe_rs;
                                if (mode_reg)
                                begin
                                    // high nibble, then low nibble on lines 7..4
                                    res_wr.res0.bus_value  =
                                        {q_head.data[7:4], bus_reg[3:0]};
                                    res_wr.en1             = 1'b1;
                                    res_wr.res1.kind       = RK_STROBE;
                                    res_wr.res1.reg_select = strobe_rs;
                                    res_wr.res1.bus_value  =
                                        {q_head.data[3:0], bus_reg[3:0]};
                                    res_wr.res1.last       = 1'b1;
                                    res_wr.res1.wait_us    = strobe_wait;
                                    bus_next               = res_wr.res1.bus_value;
                                end
                                else
                                begin
                                    bus_next              = q_head.data;
                                    res_wr.res0.bus_value = q_head.data;
                                    res_wr.res0.last      = 1'b1;
                                    res_wr.res0.wait_us   = strobe_wait;
                                end
                            end
                            default:
                            begin
                                // undefined kinds act as a delay with d = 0, i.e. a wait of WAIT_NONE = 1
                                wait_next = WAIT_NONE;
                            end
                        endcase
                    end
                end
                default:
                begin
                    // unused function code: drop the word
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg <= '0;
            bus_reg  <= '0;
        end
        else
        begin
            wait_reg <= wait_next;
            bus_reg  <= bus_next;
        end
    end

    // ------------------------------------------------------------------
    // Result buffer and master-side packing
    // ------------------------------------------------------------------
    lcdws_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (res_wr),
        .room2      (room2),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {2'b00, out_result.wait_us, out_result.bus_value,
                      out_result.reg_select};
    assign m_tuser = out_result.kind;
    assign m_tlast = out_result.last;

endmodule

[design/lcdws_entry_queue.sv]
// ----------------------------------------------------------------------------
// lcdws_entry_queue
// Circular entry queue with a registered read of the current head entry.
// ----------------------------------------------------------------------------
module lcdws_entry_queue
    import lcdws_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_ctrl_t   ctrl,
    input  entry_t        push_entry,
    output queue_status_t status,
    output entry_t        head_entry
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    entry_t           mem [QUEUE_DEPTH];
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    entry_t           head_data_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (ctrl.push)
        begin
            tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= push_entry;
        end
    end

    // Follow the head each cycle; forward a write that lands on it
    always_ff @(posedge clk)
    begin
        if (ctrl.push && (tail_reg == head_next))
        begin
            head_data_reg <= push_entry;
        end
        else
        begin
            head_data_reg <= mem[head_next];
        end
    end

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign head_entry   = head_data_reg;

endmodule

[design/lcdws_result_fifo.sv]
// ----------------------------------------------------------------------------
// lcdws_result_fifo
// Four-entry result buffer taking up to two words per cycle.
// ----------------------------------------------------------------------------
module lcdws_result_fifo
    import lcdws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  result_wr_t wr,
    output logic       room2,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_result
);

    result_t    buf_mem [4];
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [1:0] n_wr;

    assign pop  = out_valid && out_ready;
    assign n_wr = {1'b0, wr.en0} + {1'b0, wr.en1};

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        wr_ptr_next = wr_ptr_reg + n_wr;
        count_next  = count_reg + {1'b0, n_wr} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en0)
        begin
            buf_mem[wr_ptr_reg] <= wr.res0;
        end
        if (wr.en1)
        begin
            buf_mem[wr_ptr_reg + 2'd1] <= wr.res1;
        end
    end

    assign room2      = (count_reg <= 3'd2);
    assign out_valid  = (count_reg != '0);
    assign out_result = buf_mem[rd_ptr_reg];

endmodule
